// ----- src/ile_pkg.sv -----
// shared constants and codes for the indexed list engine
package ile_pkg;

    // list storage
    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int LEN_W      = $clog2(DEPTH + 1);

    // field widths
    localparam int KIND_W   = 2;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // packed stream widths, rounded up to whole bytes
    localparam int S_DATA_W = ((POS_W + VALUE_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((VALUE_W + STATUS_W + COUNT_W + 7) / 8) * 8;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_POS = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;

endpackage

// ----- src/ile_ram.sv -----
// generic single write port ram with registered read
module ile_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/indexed_list_engine.sv -----
// indexed list engine: ordered list with insert, remove and read by position
//
//  channel   dir  tdata fields (low bit up)               tuser
//  s_axis    in   position[6:0], value[38:7], zero pad    kind[1:0]
//  m_axis    out  data[31:0], status[33:32], count[40:34] -
//
//  one transfer in at a time; s_axis_tready is high only while the sequencer idles
//  errors and a full list go straight to the result; a read fetches the entry, a remove
//  fetches it and then moves each later entry down, an insert moves each entry from the
//  insert point up and then writes the value; entries move through the single ram port pair
//  a new item is taken while the last result still waits in the output register
//  synchronous active-low reset clears the length and the handshake state only
module indexed_list_engine (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [ile_pkg::S_DATA_W-1:0] s_axis_tdata,  // position, value, pad
    input  logic [ile_pkg::KIND_W-1:0]   s_axis_tuser,  // kind
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [ile_pkg::M_DATA_W-1:0] m_axis_tdata   // data, status, count, pad
);

    import ile_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SH_RD,
        S_SH_WR,
        S_INS_WR,
        S_RD_ISS,
        S_RD_CAP,
        S_RM_RD,
        S_RM_WR,
        S_DONE
    } t_state;

    t_state                  r_state;
    logic [KIND_W-1:0]       r_kind;
    logic [DATA_WIDTH-1:0]   r_value;
    logic [ADDR_W-1:0]       r_ptr;
    logic [ADDR_W-1:0]       r_at;
    logic [LEN_W-1:0]        r_len;
    logic [LEN_W-1:0]        r_new_len;
    logic [VALUE_W-1:0]      r_res_data;
    logic [STATUS_W-1:0]     r_res_stat;
    logic                    r_out_valid;
    logic [VALUE_W-1:0]      r_out_data;
    logic [STATUS_W-1:0]     r_out_stat;
    logic [COUNT_W-1:0]      r_out_cnt;

    logic                    in_xfer;
    logic [POS_W-1:0]        in_pos;
    logic [DATA_WIDTH-1:0]   in_value;
    logic                    pos_neg;
    logic [LEN_W-1:0]        pos_u;
    logic                    pos_bad;
    logic [LEN_W-1:0]        ins_clamp;
    logic [ADDR_W-1:0]       ins_at;
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [DATA_WIDTH-1:0]   ram_wdata;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [DATA_WIDTH-1:0]   ram_rdata;

    // input field unpacking and position decode
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign in_pos   = s_axis_tdata[POS_W-1:0];
    assign in_value = s_axis_tdata[POS_W +: DATA_WIDTH];
    assign pos_neg  = in_pos[POS_W-1];
    assign pos_u    = LEN_W'(in_pos[POS_W-2:0]);
    assign pos_bad  = pos_neg || (pos_u >= r_len);

    // insert point: just after the clamped position, head for negative or empty
    assign ins_clamp = (pos_u < r_len - 1'b1) ? pos_u : (r_len - 1'b1);
    assign ins_at    = (pos_neg || r_len == '0) ? '0 : ADDR_W'(ins_clamp + 1'b1);

    // ram port drive per sequencer step
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_ptr;
        ram_wdata = ram_rdata;
        ram_raddr = r_ptr;
        case (r_state)
            S_SH_RD:  ram_raddr = r_ptr - 1'b1;
            S_SH_WR:  ram_we    = 1'b1;
            S_INS_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_at;
                ram_wdata = r_value;
            end
            S_RM_RD:  ram_raddr = r_ptr + 1'b1;
            S_RM_WR:  ram_we    = 1'b1;
            default:  ram_raddr = r_ptr;
        endcase
    end

    ile_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // sequencer, length and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_kind     <= s_axis_tuser;
                        r_value    <= in_value;
                        r_res_data <= '0;
                        r_res_stat <= STAT_OK;
                        r_new_len  <= r_len;
                        case (s_axis_tuser)
                            KIND_INSERT: begin
                                if (r_len >= LEN_W'(DEPTH)) begin
                                    r_res_stat <= STAT_FULL;
                                    r_state    <= S_DONE;
                                end else begin
                                    r_at      <= ins_at;
                                    r_ptr     <= ADDR_W'(r_len);
                                    r_new_len <= r_len + 1'b1;
                                    if (r_len > LEN_W'(ins_at)) begin
                                        r_state <= S_SH_RD;
                                    end else begin
                                        r_state <= S_INS_WR;
                                    end
                                end
                            end
                            KIND_REMOVE: begin
                                if (pos_bad) begin
                                    r_res_stat <= STAT_BAD_POS;
                                    r_state    <= S_DONE;
                                end else begin
                                    r_ptr     <= ADDR_W'(pos_u);
                                    r_new_len <= r_len - 1'b1;
                                    r_state   <= S_RD_ISS;
                                end
                            end
                            KIND_READ: begin
                                if (pos_bad) begin
                                    r_res_stat <= STAT_BAD_POS;
                                    r_state    <= S_DONE;
                                end else begin
                                    r_ptr   <= ADDR_W'(pos_u);
                                    r_state <= S_RD_ISS;
                                end
                            end
                            default: begin
                                r_res_stat <= STAT_BAD_POS;
                                r_state    <= S_DONE;
                            end
                        endcase
                    end
                end
                // insert: move entries up one place, from the tail down
                S_SH_RD: r_state <= S_SH_WR;
                S_SH_WR: begin
                    r_ptr <= r_ptr - 1'b1;
                    if (r_ptr - 1'b1 == r_at) begin
                        r_state <= S_INS_WR;
                    end else begin
                        r_state <= S_SH_RD;
                    end
                end
                S_INS_WR: r_state <= S_DONE;
                // read and remove: fetch the entry at the position
                S_RD_ISS: r_state <= S_RD_CAP;
                S_RD_CAP: begin
                    r_res_data <= VALUE_W'(ram_rdata);
                    if (r_kind == KIND_REMOVE && (LEN_W'(r_ptr) + 1'b1) < r_len) begin
                        r_state <= S_RM_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                // remove: move entries down one place, from the gap up
                S_RM_RD: r_state <= S_RM_WR;
                S_RM_WR: begin
                    r_ptr <= r_ptr + 1'b1;
                    if ((LEN_W'(r_ptr) + LEN_W'(2)) < r_len) begin
                        r_state <= S_RM_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                // hand the result over once the output register is free
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res_data;
                        r_out_stat  <= r_res_stat;
                        r_out_cnt   <= COUNT_W'(r_new_len);
                        r_len       <= r_new_len;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // handshake and output packing
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_DATA_W'({r_out_cnt, r_out_stat, r_out_data});

endmodule

// ----- src/ile_checker.sv -----
// port-level assertions for the indexed list engine, bound to the top level
module ile_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic [ile_pkg::S_DATA_W-1:0] s_axis_tdata,
    input logic [ile_pkg::KIND_W-1:0]   s_axis_tuser,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [ile_pkg::M_DATA_W-1:0] m_axis_tdata
);

    import ile_pkg::*;

    logic [VALUE_W-1:0]  mon_data;
    logic [STATUS_W-1:0] mon_stat;
    logic [COUNT_W-1:0]  mon_cnt;

    assign mon_data = m_axis_tdata[VALUE_W-1:0];
    assign mon_stat = m_axis_tdata[VALUE_W +: STATUS_W];
    assign mon_cnt  = m_axis_tdata[VALUE_W + STATUS_W +: COUNT_W];

    // a failed operation never returns an entry
    a_err_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && mon_stat != STAT_OK) |-> (mon_data == '0))
        else $error("error result carries nonzero data");

    // a full status only comes with a full list
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && mon_stat == STAT_FULL) |-> (mon_cnt == COUNT_W'(DEPTH)))
        else $error("full status with list not full");

    // the result register holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    // nothing is offered straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered after reset");

endmodule

bind indexed_list_engine ile_checker u_ile_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- dv/list_checker.sv -----
// checker for the indexed list engine: mirrors the list, predicts each result and compares
module list_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [ile_pkg::S_DATA_W-1:0] s_axis_tdata,   // position, value, pad
    input  logic [ile_pkg::KIND_W-1:0]   s_axis_tuser,   // kind
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [ile_pkg::M_DATA_W-1:0] m_axis_tdata,   // data, status, count, pad
    output int                           o_fail_cnt,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ile_pkg::*;

    // result field positions in m_axis_tdata
    localparam int STATUS_LSB = VALUE_W;
    localparam int COUNT_LSB  = VALUE_W + STATUS_W;

    typedef struct packed {
        logic [VALUE_W-1:0]  data;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } t_list_result;

    // mirrored list contents and results still owed by the block
    logic [DATA_WIDTH-1:0] list_words [DEPTH];
    int                    list_len = 0;
    t_list_result          owed_results [$];
    int                    fail_cnt = 0;

    initial begin
        o_fail_cnt = 0;
        o_pending  = 0;
    end

    // apply one operation to the mirrored list and return the result it gives
    function automatic t_list_result apply_list_op(input logic [KIND_W-1:0] kind,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [VALUE_W-1:0] value);
        t_list_result res;
        int           idx;
        int           at;
        int           i;
        bit           neg;
        res = '0;
        neg = pos[POS_W-1];
        idx = int'(pos[POS_W-2:0]);
        case (kind)
            KIND_INSERT: begin
                if (list_len >= DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    // negative position or empty list goes to the head, else just after idx clamped to the last entry
                    if (neg || list_len == 0) begin
                        at = 0;
                    end else begin
                        at = ((idx < list_len - 1) ? idx : list_len - 1) + 1;
                    end
                    for (i = list_len; i > at; i--) begin
                        list_words[i] = list_words[i-1];
                    end
                    list_words[at] = value;
                    list_len++;
                end
            end
            KIND_REMOVE: begin
                if (neg || idx >= list_len) begin
                    res.status = STAT_BAD_POS;
                end else begin
                    res.data = list_words[idx];
                    for (i = idx; i + 1 < list_len; i++) begin
                        list_words[i] = list_words[i+1];
                    end
                    list_len--;
                end
            end
            KIND_READ: begin
                if (neg || idx >= list_len) begin
                    res.status = STAT_BAD_POS;
                end else begin
                    res.data = list_words[idx];
                end
            end
            default: begin
                res.status = STAT_BAD_POS;
            end
        endcase
        res.count = COUNT_W'(list_len);
        return res;
    endfunction

    task automatic flag_field(input string field, input logic [VALUE_W-1:0] want,
                              input logic [VALUE_W-1:0] got);
        fail_cnt++;
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endtask

    // watch both channels; a result is checked before the new transfer is predicted
    always @(posedge i_clk) begin : watch
        t_list_result got;
        t_list_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.data   = m_axis_tdata[VALUE_W-1:0];
                got.status = m_axis_tdata[STATUS_LSB +: STATUS_W];
                got.count  = m_axis_tdata[COUNT_LSB +: COUNT_W];
                if (owed_results.size() == 0) begin
                    fail_cnt++;
                    $display("%0t ns: result with none expected, expected nothing, actual %h",
                             $time, m_axis_tdata);
                end else begin
                    want = owed_results.pop_front();
                    if (got.data !== want.data) begin
                        flag_field("data", want.data, got.data);
                    end
                    if (got.status !== want.status) begin
                        flag_field("status", want.status, got.status);
                    end
                    if (got.count !== want.count) begin
                        flag_field("count", want.count, got.count);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                owed_results.push_back(apply_list_op(s_axis_tuser,
                                                     s_axis_tdata[POS_W-1:0],
                                                     s_axis_tdata[POS_W +: VALUE_W]));
            end
        end
        o_fail_cnt <= fail_cnt;
        o_pending  <= owed_results.size();
    end

endmodule

// ----- dv/tb_top.sv -----
// testbench top for the indexed list engine: clock, reset, stimulus and verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ile_pkg::*;

    localparam int ITEMS        = 1850;
    localparam int RUN_LIMIT    = 1500000;
    localparam int IDLE_PCT     = 18;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 300;
    localparam int CALM_FROM    = 900;
    localparam int CALM_TO      = 1200;
    localparam int DRAIN_CYCLES = 300;
    localparam int PAD_W        = S_DATA_W - POS_W - VALUE_W;

    // the one kind code the block does not define
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} t_mode;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;   // position, value, pad
    logic [KIND_W-1:0]   s_axis_tuser  = '0;   // kind
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;         // data, status, count, pad

    int   fail_cnt;
    int   pending;
    int   sent_cnt = 0;
    int   list_len = 0;   // length as seen by the stimulus, used to aim positions
    logic calm;

    assign calm = (sent_cnt >= CALM_FROM) && (sent_cnt < CALM_TO);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    indexed_list_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    list_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_cnt    (fail_cnt),
        .o_pending     (pending)
    );

    // offer one operation, with a random gap first, and wait for its transfer
    task automatic send_op(input logic [KIND_W-1:0] kind, input int pos,
                           input logic [VALUE_W-1:0] value);
        logic [POS_W-1:0] p;
        p = pos[POS_W-1:0];
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {{PAD_W{1'b0}}, value, p};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        if (kind == KIND_INSERT && list_len < DEPTH) begin
            list_len++;
        end else if (kind == KIND_REMOVE && !p[POS_W-1] && int'(p[POS_W-2:0]) < list_len) begin
            list_len--;
        end
        sent_cnt++;
    endtask

    // mostly positions inside the list, with the ends, the far range and negatives mixed in
    function automatic int pick_pos();
        int r;
        r = $urandom_range(99);
        if (r < 8) begin
            return -int'($urandom_range(64, 1));
        end
        if (r < 18 || list_len == 0) begin
            return int'($urandom_range(63, 0));
        end
        if (r < 28) begin
            return (r < 23) ? 0 : list_len - 1;
        end
        return int'($urandom_range(list_len - 1, 0));
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(39))
            0:       return '0;
            1:       return '1;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind(input t_mode mode);
        int r;
        r = $urandom_range(99);
        if (r < 3) begin
            return KIND_UNUSED;
        end
        case (mode)
            MODE_FILL:  return (r < 80) ? KIND_INSERT : (r < 90) ? KIND_READ : KIND_REMOVE;
            MODE_DRAIN: return (r < 72) ? KIND_REMOVE : (r < 90) ? KIND_READ : KIND_INSERT;
            default:    return (r < 36) ? KIND_INSERT : (r < 68) ? KIND_READ : KIND_REMOVE;
        endcase
    endfunction

    // stimulus: directed cases, a fill to full, then random phases
    initial begin : stimulus
        t_mode mode;
        int    phase_left;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list and the unused kind
        send_op(KIND_READ,   0, '0);
        send_op(KIND_REMOVE, 0, '0);
        send_op(KIND_UNUSED, 0, '0);
        // head inserts, clamp past the end, inserts in the middle and at the exact end
        send_op(KIND_INSERT, -64, 32'h7FFF_FFFF);
        send_op(KIND_INSERT, 63,  32'h8000_0000);
        send_op(KIND_INSERT, -1,  32'hFFFF_FFFF);
        send_op(KIND_INSERT, 0,   32'h5555_5555);
        send_op(KIND_INSERT, 1,   32'hAAAA_AAAA);
        send_op(KIND_INSERT, 4,   32'h0000_0000);
        // reads at both ends and just off them
        send_op(KIND_READ, 0,   '0);
        send_op(KIND_READ, 5,   '0);
        send_op(KIND_READ, 6,   '0);
        send_op(KIND_READ, 63,  '0);
        send_op(KIND_READ, -1,  '0);
        send_op(KIND_READ, -64, '0);
        // removes: bad positions, middle, last, first
        send_op(KIND_REMOVE, -1, '0);
        send_op(KIND_REMOVE, 6,  '0);
        send_op(KIND_REMOVE, 2,  '0);
        send_op(KIND_REMOVE, 4,  '0);
        send_op(KIND_REMOVE, 0,  '0);
        send_op(KIND_UNUSED, -1, '1);
        send_op(KIND_READ,   0,  '0);

        // fill to the brim, then insert into the full list
        while (list_len < DEPTH) begin
            send_op(KIND_INSERT, pick_pos(), pick_value());
        end
        repeat (4) send_op(KIND_INSERT, pick_pos(), pick_value());

        // random phases leaning to fill, drain or a mix
        while (sent_cnt < ITEMS) begin
            mode       = t_mode'($urandom_range(2));
            phase_left = $urandom_range(120, 20);
            while (phase_left > 0 && sent_cnt < ITEMS) begin
                send_op(pick_kind(mode), pick_pos(), pick_value());
                phase_left--;
            end
        end
        s_axis_tvalid <= 1'b0;

        // let the last results out, then a quiet stretch for strays
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // receiver: random back-pressure, one long hold-off so the input stalls
    initial begin : sink
        bit held;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && sent_cnt >= HOLD_AT) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // cycle limit
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- indexed_list_engine.f -----
src/ile_pkg.sv
src/ile_ram.sv
src/indexed_list_engine.sv
src/ile_checker.sv
dv/list_checker.sv
dv/tb_top.sv
